>>> rtl/cso_pkg.sv
// Package for the course and ground speed block: widths, fixed-point constants,
// mode codes, pipeline types and the CORDIC arctangent table.
// No dependencies.
package cso_pkg;

  localparam int VELOCITY_BITS = 24;
  localparam int CORDIC_STEPS  = 20;
  localparam int GUARD_BITS    = 8;

  localparam int XW     = VELOCITY_BITS + GUARD_BITS + 4;
  localparam int ZW     = 30;
  localparam int STEP_W = 5;
  localparam int MAG_W  = (XW - 1 > 32) ? XW - 1 : 33;
  localparam int HI_W   = MAG_W - 32;
  localparam int PROD_W = MAG_W + 1;
  localparam int RND_W  = PROD_W + 1;
  localparam int TW     = ZW + 1 - 16;

  localparam logic signed [ZW-1:0] QUARTER_UNITS = ZW'(900 * 65536);
  localparam logic signed [ZW:0]   FULL_UNITS    = (ZW + 1)'(3600 * 65536);
  localparam logic signed [ZW:0]   HALF_TENTH    = (ZW + 1)'(32768);

  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam logic [31:0] KNOTS_Q32    = 32'd506980204;
  localparam logic [31:0] KPH_Q32      = 32'd938927339;
  localparam logic [21:0] KNOTS_MAX    = 22'd2306100;
  localparam logic [22:0] KPH_MAX      = 23'd4270800;
  localparam logic [11:0] COURSE_WRAP  = 12'd3600;

  localparam logic [2:0] PMODE_SINGLE = 3'd1;
  localparam logic [2:0] PMODE_DIFF   = 3'd2;
  localparam logic [2:0] PMODE_FLOAT  = 3'd3;
  localparam logic [2:0] PMODE_FIXED  = 3'd4;

  localparam logic [1:0] IND_NONE  = 2'd0;
  localparam logic [1:0] IND_AUTON = 2'd1;
  localparam logic [1:0] IND_DIFF  = 2'd2;

  localparam logic [15:0] SPEED_LIMIT_RST = 16'd100;

  typedef logic signed [XW-1:0]    xw_t;
  typedef logic signed [ZW:0]      zx_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [63:0]             lprod_t;
  typedef logic [HI_W+31:0]        hprod_t;
  typedef logic [PROD_W-1:0]       prod_t;
  typedef logic [RND_W-1:0]        rnd_t;

  typedef struct packed {
    logic       zero;
    logic       vvalid;
    logic [1:0] mode;
    logic       status;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_units(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:    r = ZW'(29491200);
      5'd1:    r = ZW'(17409672);
      5'd2:    r = ZW'(9198793);
      5'd3:    r = ZW'(4669451);
      5'd4:    r = ZW'(2343787);
      5'd5:    r = ZW'(1173036);
      5'd6:    r = ZW'(586661);
      5'd7:    r = ZW'(293348);
      5'd8:    r = ZW'(146676);
      5'd9:    r = ZW'(73339);
      5'd10:   r = ZW'(36669);
      5'd11:   r = ZW'(18335);
      5'd12:   r = ZW'(9167);
      5'd13:   r = ZW'(4584);
      5'd14:   r = ZW'(2292);
      5'd15:   r = ZW'(1146);
      5'd16:   r = ZW'(573);
      5'd17:   r = ZW'(286);
      5'd18:   r = ZW'(143);
      5'd19:   r = ZW'(72);
      5'd20:   r = ZW'(36);
      5'd21:   r = ZW'(18);
      5'd22:   r = ZW'(9);
      5'd23:   r = ZW'(4);
      5'd24:   r = ZW'(2);
      5'd25:   r = ZW'(1);
      5'd26:   r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cso_if.sv
// Channel interfaces: velocity input, result output and configuration write.
// Depends on cso_pkg.
interface cso_vel_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [cso_pkg::VELOCITY_BITS-1:0]  velocity_north;
  logic signed [cso_pkg::VELOCITY_BITS-1:0]  velocity_east;
  logic [2:0]                                position_mode;
  logic                                      velocity_valid;
  modport source (output valid, velocity_north, velocity_east, position_mode,
                  velocity_valid, input ready);
  modport sink   (input valid, velocity_north, velocity_east, position_mode,
                  velocity_valid, output ready);
endinterface

interface cso_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] course_tenths;
  logic        course_valid;
  logic [21:0] speed_knots_hundredths;
  logic [22:0] speed_kph_hundredths;
  logic        speed_valid;
  logic [1:0]  mode_indicator;
  logic        status_active;
  modport source (output valid, course_tenths, course_valid, speed_knots_hundredths,
                  speed_kph_hundredths, speed_valid, mode_indicator, status_active,
                  input ready);
  modport sink   (input valid, course_tenths, course_valid, speed_knots_hundredths,
                  speed_kph_hundredths, speed_valid, mode_indicator, status_active,
                  output ready);
endinterface

interface cso_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] static_speed_limit;
  modport source (output valid, static_speed_limit, input ready);
  modport sink   (input valid, static_speed_limit, output ready);
endinterface

>>> rtl/cso_prerot.sv
// Input stage: scales the velocity beat, folds it into the right half plane
// and decodes the position mode. Depends on cso_pkg and cso_if.
module cso_prerot (
  input  logic            clk_i,
  input  logic            rst_ni,
  cso_vel_if.sink         vel_i,
  output logic            valid_o,
  output cso_pkg::cord_t  data_o,
  input  logic            ready_i
);

  logic           valid_q;
  cso_pkg::cord_t data_q, data_d;
  cso_pkg::xw_t   nx, ey;
  logic           adv;

  assign adv         = !valid_q || ready_i;
  assign vel_i.ready = adv;

  always_comb begin
    nx = cso_pkg::xw_t'(vel_i.velocity_north) <<< cso_pkg::GUARD_BITS;
    ey = cso_pkg::xw_t'(vel_i.velocity_east) <<< cso_pkg::GUARD_BITS;
    data_d.x = nx;
    data_d.y = ey;
    data_d.z = '0;
    if (nx < 0) begin
      if (ey >= 0) begin
        data_d.x = ey;
        data_d.y = -nx;
        data_d.z = cso_pkg::QUARTER_UNITS;
      end else begin
        data_d.x = -ey;
        data_d.y = nx;
        data_d.z = -cso_pkg::QUARTER_UNITS;
      end
    end
    data_d.side.zero   = (vel_i.velocity_north == '0) && (vel_i.velocity_east == '0);
    data_d.side.vvalid = vel_i.velocity_valid;
    case (vel_i.position_mode)
      cso_pkg::PMODE_SINGLE: begin
        data_d.side.mode   = cso_pkg::IND_AUTON;
        data_d.side.status = 1'b1;
      end
      cso_pkg::PMODE_DIFF, cso_pkg::PMODE_FLOAT, cso_pkg::PMODE_FIXED: begin
        data_d.side.mode   = cso_pkg::IND_DIFF;
        data_d.side.status = 1'b1;
      end
      default: begin
        data_d.side.mode   = cso_pkg::IND_NONE;
        data_d.side.status = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= vel_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vel_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/cso_cell.sv
// One CORDIC vectoring cell: a micro-rotation by atan(2^-step) and a register.
// Depends on cso_pkg.
module cso_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cso_pkg::STEP_W-1:0]   step_i,
  input  logic                         valid_i,
  input  cso_pkg::cord_t               data_i,
  output logic                         ready_o,
  output logic                         valid_o,
  output cso_pkg::cord_t               data_o,
  input  logic                         ready_i
);

  logic                          valid_q;
  cso_pkg::cord_t                data_q, data_d;
  logic signed [cso_pkg::ZW-1:0] atan;

  assign ready_o = !valid_q || ready_i;
  assign atan    = cso_pkg::atan_units(step_i);

  always_comb begin
    data_d = data_i;
    if (!data_i.y[cso_pkg::XW-1]) begin
      data_d.x = data_i.x + (data_i.y >>> step_i);
      data_d.y = data_i.y - (data_i.x >>> step_i);
      data_d.z = data_i.z + atan;
    end else begin
      data_d.x = data_i.x - (data_i.y >>> step_i);
      data_d.y = data_i.y + (data_i.x >>> step_i);
      data_d.z = data_i.z - atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/cso_post.sv
// Output stages: gain/unit multiplies and course wrap, then rounding,
// saturation, static-speed test and the result register.
// Depends on cso_pkg and cso_if.
module cso_post (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     limit_i,
  input  logic            valid_i,
  input  cso_pkg::cord_t  data_i,
  output logic            ready_o,
  cso_res_if.source       res_o
);

  // stage 1
  logic                    s1_valid_q;
  cso_pkg::lprod_t         fine_lo_q, knots_lo_q, kph_lo_q;
  cso_pkg::hprod_t         fine_hi_q, knots_hi_q, kph_hi_q;
  logic [11:0]             tenths_q, tenths_d;
  cso_pkg::side_t          side_q;
  cso_pkg::mag_t           mag;
  logic [31:0]             lo;
  logic [cso_pkg::HI_W-1:0] hi;
  cso_pkg::zx_t            zz;
  logic [cso_pkg::TW-1:0]  tr;
  logic                    s1_adv;

  // stage 2
  logic                    s2_valid_q;
  logic                    s2_adv;
  cso_pkg::prod_t          fine, knots, kph;
  cso_pkg::rnd_t           knots_r, kph_r;
  logic                    cvalid;

  logic [11:0]             course_q;
  logic                    cvalid_q;
  logic [21:0]             knots_q, knots_d;
  logic [22:0]             kph_q, kph_d;
  cso_pkg::side_t          side2_q;

  assign s2_adv  = !s2_valid_q || res_o.ready;
  assign s1_adv  = !s1_valid_q || s2_adv;
  assign ready_o = s1_adv;

  always_comb begin
    mag = data_i.x[cso_pkg::XW-1] ? '0 : cso_pkg::mag_t'(data_i.x[cso_pkg::XW-2:0]);
    lo  = mag[31:0];
    hi  = mag[cso_pkg::MAG_W-1:32];
    zz  = data_i.side.zero ? '0 : cso_pkg::zx_t'(data_i.z);
    if (zz < 0) begin
      zz = zz + cso_pkg::FULL_UNITS;
    end
    if (zz < 0) begin
      zz = '0;
    end
    zz = zz + cso_pkg::HALF_TENTH;
    tr = zz[cso_pkg::ZW:16];
    if (tr >= cso_pkg::TW'(cso_pkg::COURSE_WRAP)) begin
      tenths_d = '0;
    end else begin
      tenths_d = tr[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && valid_i) begin
      fine_lo_q  <= cso_pkg::lprod_t'(lo) * cso_pkg::lprod_t'(cso_pkg::INV_GAIN_Q32);
      knots_lo_q <= cso_pkg::lprod_t'(lo) * cso_pkg::lprod_t'(cso_pkg::KNOTS_Q32);
      kph_lo_q   <= cso_pkg::lprod_t'(lo) * cso_pkg::lprod_t'(cso_pkg::KPH_Q32);
      fine_hi_q  <= cso_pkg::hprod_t'(hi) * cso_pkg::hprod_t'(cso_pkg::INV_GAIN_Q32);
      knots_hi_q <= cso_pkg::hprod_t'(hi) * cso_pkg::hprod_t'(cso_pkg::KNOTS_Q32);
      kph_hi_q   <= cso_pkg::hprod_t'(hi) * cso_pkg::hprod_t'(cso_pkg::KPH_Q32);
      tenths_q   <= tenths_d;
      side_q     <= data_i.side;
    end
  end

  always_comb begin
    fine    = cso_pkg::prod_t'(fine_hi_q) + cso_pkg::prod_t'(fine_lo_q[63:32]);
    knots   = cso_pkg::prod_t'(knots_hi_q) + cso_pkg::prod_t'(knots_lo_q[63:32]);
    kph     = cso_pkg::prod_t'(kph_hi_q) + cso_pkg::prod_t'(kph_lo_q[63:32]);
    knots_r = (cso_pkg::rnd_t'(knots) + cso_pkg::rnd_t'(1 << (cso_pkg::GUARD_BITS - 1)))
              >> cso_pkg::GUARD_BITS;
    kph_r   = (cso_pkg::rnd_t'(kph) + cso_pkg::rnd_t'(1 << (cso_pkg::GUARD_BITS - 1)))
              >> cso_pkg::GUARD_BITS;
    if (!side_q.vvalid) begin
      knots_d = '0;
    end else if (knots_r > cso_pkg::rnd_t'(cso_pkg::KNOTS_MAX)) begin
      knots_d = cso_pkg::KNOTS_MAX;
    end else begin
      knots_d = knots_r[21:0];
    end
    if (!side_q.vvalid) begin
      kph_d = '0;
    end else if (kph_r > cso_pkg::rnd_t'(cso_pkg::KPH_MAX)) begin
      kph_d = cso_pkg::KPH_MAX;
    end else begin
      kph_d = kph_r[22:0];
    end
    cvalid = side_q.vvalid &&
             (fine > (cso_pkg::prod_t'(limit_i) << cso_pkg::GUARD_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      course_q <= cvalid ? tenths_q : '0;
      cvalid_q <= cvalid;
      knots_q  <= knots_d;
      kph_q    <= kph_d;
      side2_q  <= side_q;
    end
  end

  assign res_o.valid                  = s2_valid_q;
  assign res_o.course_tenths          = course_q;
  assign res_o.course_valid           = cvalid_q;
  assign res_o.speed_knots_hundredths = knots_q;
  assign res_o.speed_kph_hundredths   = kph_q;
  assign res_o.speed_valid            = side2_q.vvalid;
  assign res_o.mode_indicator         = side2_q.mode;
  assign res_o.status_active          = side2_q.status;

endmodule

>>> rtl/course_speed_over_ground.sv
// Course and ground speed: input stage, CORDIC_STEPS CORDIC cells, two output stages.
// Throughput: one beat per cycle while res_o.ready is high; every stage holds its own
// beat, so bubbles close up.
// Reset: asynchronous active low, clears all stage valids; speed limit returns to 100.
// Depends on cso_pkg, cso_if, cso_prerot, cso_cell and cso_post.
module course_speed_over_ground (
  input  logic       clk_i,
  input  logic       rst_ni,
  cso_cfg_if.sink    cfg_i,
  cso_vel_if.sink    vel_i,
  cso_res_if.source  res_o
);

  localparam int N = cso_pkg::CORDIC_STEPS;

  logic [15:0]    limit_q;
  logic           cv [N+1];
  logic           cr [N+1];
  cso_pkg::cord_t cd [N+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= cso_pkg::SPEED_LIMIT_RST;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.static_speed_limit;
    end
  end

  cso_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vel_i   (vel_i),
    .valid_o (cv[0]),
    .data_o  (cd[0]),
    .ready_i (cr[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned StepI = g;
    cso_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (StepI[cso_pkg::STEP_W-1:0]),
      .valid_i (cv[g]),
      .data_i  (cd[g]),
      .ready_o (cr[g]),
      .valid_o (cv[g+1]),
      .data_o  (cd[g+1]),
      .ready_i (cr[g+1])
    );
  end

  cso_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .limit_i (limit_q),
    .valid_i (cv[N]),
    .data_i  (cd[N]),
    .ready_o (cr[N]),
    .res_o   (res_o)
  );

endmodule

>>> rtl/cso_checker.sv
// Port-level checker for course_speed_over_ground, attached by bind.
// Depends on cso_pkg and the top level's interface ports.
module cso_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [11:0] course_tenths_i,
  input logic        course_valid_i,
  input logic [21:0] knots_i,
  input logic [22:0] kph_i,
  input logic        speed_valid_i,
  input logic [1:0]  mode_indicator_i,
  input logic        status_active_i
);

  a_course_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && course_valid_i |-> speed_valid_i && course_tenths_i < 12'd3600)
    else $error("course valid with bad range or speed invalid");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !speed_valid_i |->
      knots_i == '0 && kph_i == '0 && course_tenths_i == '0 && !course_valid_i)
    else $error("invalid velocity beat carries nonzero outputs");

  a_mode_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (status_active_i == (mode_indicator_i != cso_pkg::IND_NONE)) &&
      (mode_indicator_i == cso_pkg::IND_NONE || mode_indicator_i == cso_pkg::IND_AUTON ||
       mode_indicator_i == cso_pkg::IND_DIFF))
    else $error("mode indicator and status disagree");

  a_course_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !course_valid_i |-> course_tenths_i == '0)
    else $error("course not zeroed when invalid");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(course_tenths_i) &&
      $stable(knots_i) && $stable(kph_i))
    else $error("result beat changed while stalled");

endmodule

bind course_speed_over_ground cso_checker u_cso_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .course_tenths_i  (res_o.course_tenths),
  .course_valid_i   (res_o.course_valid),
  .knots_i          (res_o.speed_knots_hundredths),
  .kph_i            (res_o.speed_kph_hundredths),
  .speed_valid_i    (res_o.speed_valid),
  .mode_indicator_i (res_o.mode_indicator),
  .status_active_i  (res_o.status_active)
);

>>> verif/course_speed_over_ground_tb.sv
// Testbench for course_speed_over_ground: drives velocity beats and limit writes, checks
// every result beat against a pinned fix or a bit-true predictor, random stalls both ways.
// Depends on cso_pkg, cso_if and the course_speed_over_ground RTL.
module course_speed_over_ground_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB            = cso_pkg::VELOCITY_BITS;
  localparam int VEL_MAX       = 2 ** (VB - 1) - 1;
  localparam int VEL_MIN       = -(2 ** (VB - 1));
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 312;
  localparam int LONG_HOLD     = 300;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int MAX_REPORTS   = 100;
  localparam int DRAIN_CYCLES  = cso_pkg::CORDIC_STEPS + 13;

  localparam logic [2:0] PMODE_NONE    = 3'd0;
  localparam logic [2:0] PMODE_UNSUP_5 = 3'd5;
  localparam logic [2:0] PMODE_UNSUP_6 = 3'd6;
  localparam logic [2:0] PMODE_UNSUP_7 = 3'd7;

  localparam longint QUARTER_TURN = 900 * 65536;
  localparam longint FULL_TURN    = 3600 * 65536;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [VB-1:0] north;
    logic signed [VB-1:0] east;
    logic [2:0]           pmode;
    logic                 vvalid;
  } vel_sample_t;

  typedef struct packed {
    logic [11:0] course_tenths;
    logic        course_valid;
    logic [21:0] knots;
    logic [22:0] kph;
    logic        speed_valid;
    logic [1:0]  mode_ind;
    logic        status;
  } cog_fix_t;

  typedef struct {
    vel_sample_t s;
    bit          pinned;
    cog_fix_t    want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cso_cfg_if cfg_ch ();
  cso_vel_if vel_ch ();
  cso_res_if res_ch ();

  course_speed_over_ground uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .vel_i  (vel_ch),
    .res_o  (res_ch)
  );

  longint atan_tab [32] = '{
    29491200, 17409672, 9198793, 4669451, 2343787, 1173036, 586661, 293348,
    146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146,
    573, 286, 143, 72, 36, 18, 9, 4,
    2, 1, 1, 0, 0, 0, 0, 0
  };

  cog_fix_t    expected_fixes [$];
  dir_row_t    dir_rows [$];
  logic [15:0] speed_limit_q = cso_pkg::SPEED_LIMIT_RST;
  int          fails = 0;
  int          snd_gap_pct = 0;
  int          res_gap_pct = 0;
  bit          hold_long = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic u64_t scale_q32(input u64_t m, input u64_t c);
    return (m >> 32) * c + (((m & 64'hFFFF_FFFF) * c) >> 32);
  endfunction

  function automatic cog_fix_t predict_fix(input vel_sample_t s, input logic [15:0] lim);
    longint   x, y, z, t, dx, dy;
    u64_t     mag, fine, knots, kph, tenths;
    cog_fix_t r;
    x = longint'(s.north) * (longint'(1) << cso_pkg::GUARD_BITS);
    y = longint'(s.east) * (longint'(1) << cso_pkg::GUARD_BITS);
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t; z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < cso_pkg::CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    mag = (x > 0) ? u64_t'(x) : 64'd0;
    if (s.north == 0 && s.east == 0) z = 0;
    if (z < 0) z += FULL_TURN;
    if (z < 0) z = 0;
    tenths = (u64_t'(z) + 32768) >> 16;
    if (tenths >= cso_pkg::COURSE_WRAP) tenths = 0;
    fine  = scale_q32(mag, cso_pkg::INV_GAIN_Q32);
    knots = (scale_q32(mag, cso_pkg::KNOTS_Q32) + (u64_t'(1) << (cso_pkg::GUARD_BITS - 1)))
            >> cso_pkg::GUARD_BITS;
    kph   = (scale_q32(mag, cso_pkg::KPH_Q32) + (u64_t'(1) << (cso_pkg::GUARD_BITS - 1)))
            >> cso_pkg::GUARD_BITS;
    if (knots > cso_pkg::KNOTS_MAX) knots = cso_pkg::KNOTS_MAX;
    if (kph > cso_pkg::KPH_MAX) kph = cso_pkg::KPH_MAX;
    r.course_valid = s.vvalid && (fine > (u64_t'(lim) << cso_pkg::GUARD_BITS));
    r.course_tenths = r.course_valid ? tenths[11:0] : 12'd0;
    r.knots = s.vvalid ? knots[21:0] : 22'd0;
    r.kph = s.vvalid ? kph[22:0] : 23'd0;
    r.speed_valid = s.vvalid;
    case (s.pmode)
      cso_pkg::PMODE_SINGLE: r.mode_ind = cso_pkg::IND_AUTON;
      cso_pkg::PMODE_DIFF, cso_pkg::PMODE_FLOAT, cso_pkg::PMODE_FIXED:
        r.mode_ind = cso_pkg::IND_DIFF;
      default: r.mode_ind = cso_pkg::IND_NONE;
    endcase
    r.status = (r.mode_ind != cso_pkg::IND_NONE);
    return r;
  endfunction

  function automatic vel_sample_t mk_sample(input int n, input int e, input logic [2:0] pm,
                                            input bit vv);
    vel_sample_t s;
    s.north  = VB'(n);
    s.east   = VB'(e);
    s.pmode  = pm;
    s.vvalid = vv;
    return s;
  endfunction

  function automatic dir_row_t pred_row(input int n, input int e, input logic [2:0] pm,
                                        input bit vv);
    dir_row_t d;
    d.s      = mk_sample(n, e, pm, vv);
    d.pinned = 1'b0;
    d.want   = '0;
    return d;
  endfunction

  function automatic dir_row_t pinned_row(input int n, input int e, input logic [2:0] pm,
                                          input bit vv, input cog_fix_t want);
    dir_row_t d;
    d.s      = mk_sample(n, e, pm, vv);
    d.pinned = 1'b1;
    d.want   = want;
    return d;
  endfunction

  function automatic int small_signed(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int extreme_val();
    if ($urandom_range(0, 1)) return VEL_MAX - int'($urandom_range(0, 3));
    return VEL_MIN + int'($urandom_range(0, 3));
  endfunction

  function automatic vel_sample_t random_sample(input logic [15:0] lim);
    int n, e, near;
    case ($urandom_range(0, 5))
      0: begin
        n = $urandom; e = $urandom;
      end
      1: begin
        n = small_signed(2000); e = small_signed(2000);
      end
      2: begin
        // speed right around the static limit, mostly along one axis
        near = int'(lim) + small_signed(2);
        if ($urandom_range(0, 1)) near = -near;
        if ($urandom_range(0, 1)) begin
          n = near; e = small_signed(3);
        end else begin
          n = small_signed(3); e = near;
        end
      end
      3: begin
        n = int'($urandom) >>> $urandom_range(8, 31);
        e = int'($urandom) >>> $urandom_range(8, 31);
      end
      4: begin
        n = extreme_val(); e = extreme_val();
      end
      default: begin
        n = small_signed(1); e = small_signed(1);
      end
    endcase
    return mk_sample(n, e, 3'($urandom_range(0, 7)), $urandom_range(0, 4) != 0);
  endfunction

  task automatic send_beat(input vel_sample_t s, input bit pinned, input cog_fix_t want);
    if (snd_gap_pct != 0 && $urandom_range(1, 100) <= snd_gap_pct) begin
      @(negedge clk_i);
      vel_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk_i);
    end
    @(negedge clk_i);
    vel_ch.valid          <= 1'b1;
    vel_ch.velocity_north <= s.north;
    vel_ch.velocity_east  <= s.east;
    vel_ch.position_mode  <= s.pmode;
    vel_ch.velocity_valid <= s.vvalid;
    do @(posedge clk_i); while (!vel_ch.ready);
    expected_fixes.push_back(pinned ? want : predict_fix(s, speed_limit_q));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    vel_ch.valid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(negedge clk_i);
    cfg_ch.valid              <= 1'b1;
    cfg_ch.static_speed_limit <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    speed_limit_q = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input u64_t want, input u64_t got);
    if (want != got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    cog_fix_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_fixes.size() == 0) begin
        fails++;
        $display("%0t ns: unexpected result beat, expected none actual course %0d",
                 $time, res_ch.course_tenths);
      end else begin
        want = expected_fixes.pop_front();
        compare_field("course_tenths", want.course_tenths, res_ch.course_tenths);
        compare_field("course_valid", want.course_valid, res_ch.course_valid);
        compare_field("speed_knots_hundredths", want.knots, res_ch.speed_knots_hundredths);
        compare_field("speed_kph_hundredths", want.kph, res_ch.speed_kph_hundredths);
        compare_field("speed_valid", want.speed_valid, res_ch.speed_valid);
        compare_field("mode_indicator", want.mode_ind, res_ch.mode_indicator);
        compare_field("status_active", want.status, res_ch.status_active);
      end
    end
  end

  initial begin : result_drain
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_long) begin
        hold_long = 1'b0;
        hold_left = LONG_HOLD - 1;
        res_ch.ready <= 1'b0;
      end else if (res_gap_pct != 0 && $urandom_range(1, 100) <= res_gap_pct) begin
        hold_left = $urandom_range(0, 16);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk_i);
      if ((vel_ch.valid && vel_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_MAX);
    $display("** course_speed_over_ground: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] limits [PHASES];
    int          pct_menu [3];
    cog_fix_t    fix_none;
    rst_ni                    = 1'b0;
    vel_ch.valid              = 1'b0;
    vel_ch.velocity_north     = '0;
    vel_ch.velocity_east      = '0;
    vel_ch.position_mode      = PMODE_NONE;
    vel_ch.velocity_valid     = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.static_speed_limit = '0;
    pct_menu = '{0, 10, 35};
    limits = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom_range(0, 2000)),
               cso_pkg::SPEED_LIMIT_RST};
    fix_none = '{12'd0, 1'b0, 22'd0, 23'd0, 1'b0, cso_pkg::IND_NONE, 1'b0};

    // zero velocity, invalid velocity, every position mode, axis and diagonal extremes,
    // the rounding fold of 360.0 to 0, both pre-rotation quadrants, speeds at the limit
    dir_rows.push_back(pinned_row(0, 0, cso_pkg::PMODE_SINGLE, 1'b1,
      '{12'd0, 1'b0, 22'd0, 23'd0, 1'b1, cso_pkg::IND_AUTON, 1'b1}));
    dir_rows.push_back(pinned_row(0, 0, PMODE_NONE, 1'b0, fix_none));
    dir_rows.push_back(pinned_row(VEL_MAX, VEL_MAX, cso_pkg::PMODE_FIXED, 1'b0,
      '{12'd0, 1'b0, 22'd0, 23'd0, 1'b0, cso_pkg::IND_DIFF, 1'b1}));
    dir_rows.push_back(pinned_row(VEL_MIN, VEL_MIN, PMODE_UNSUP_5, 1'b0, fix_none));
    dir_rows.push_back(pinned_row(VEL_MIN, VEL_MAX, PMODE_UNSUP_6, 1'b0, fix_none));
    dir_rows.push_back(pinned_row(VEL_MAX, VEL_MIN, PMODE_UNSUP_7, 1'b0, fix_none));
    dir_rows.push_back(pred_row(VEL_MAX, 0, cso_pkg::PMODE_SINGLE, 1'b1));
    dir_rows.push_back(pred_row(VEL_MIN, 0, cso_pkg::PMODE_DIFF, 1'b1));
    dir_rows.push_back(pred_row(0, VEL_MAX, cso_pkg::PMODE_FLOAT, 1'b1));
    dir_rows.push_back(pred_row(0, VEL_MIN, cso_pkg::PMODE_FIXED, 1'b1));
    dir_rows.push_back(pred_row(VEL_MAX, VEL_MAX, cso_pkg::PMODE_SINGLE, 1'b1));
    dir_rows.push_back(pred_row(VEL_MIN, VEL_MIN, cso_pkg::PMODE_DIFF, 1'b1));
    dir_rows.push_back(pred_row(VEL_MAX, VEL_MIN, cso_pkg::PMODE_FLOAT, 1'b1));
    dir_rows.push_back(pred_row(VEL_MIN, VEL_MAX, cso_pkg::PMODE_FIXED, 1'b1));
    dir_rows.push_back(pred_row(1000000, -1, cso_pkg::PMODE_SINGLE, 1'b1));
    dir_rows.push_back(pred_row(-1000000, 1, cso_pkg::PMODE_DIFF, 1'b1));
    dir_rows.push_back(pred_row(-1000000, -1, cso_pkg::PMODE_FLOAT, 1'b1));
    dir_rows.push_back(pred_row(100, 0, cso_pkg::PMODE_FIXED, 1'b1));
    dir_rows.push_back(pred_row(101, 0, cso_pkg::PMODE_SINGLE, 1'b1));
    dir_rows.push_back(pred_row(99, 1, cso_pkg::PMODE_DIFF, 1'b1));
    dir_rows.push_back(pred_row(0, -100, cso_pkg::PMODE_FLOAT, 1'b1));
    dir_rows.push_back(pred_row(5000, 5000, PMODE_NONE, 1'b1));
    dir_rows.push_back(pred_row(-1, -1, PMODE_UNSUP_5, 1'b1));
    dir_rows.push_back(pred_row(1, 0, PMODE_UNSUP_7, 1'b1));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    res_gap_pct = 10;
    foreach (dir_rows[i]) send_beat(dir_rows[i].s, dir_rows[i].pinned, dir_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_limit(limits[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == PHASES - 1) begin
          snd_gap_pct = 0;
          res_gap_pct = 0;
        end else if (k % 64 == 0) begin
          snd_gap_pct = pct_menu[$urandom_range(0, 2)];
          res_gap_pct = pct_menu[$urandom_range(0, 2)];
        end
        if (p == 2 && k == 50) hold_long = 1'b1;
        if (p == 3 && k == 150) drain_results();
        send_beat(random_sample(speed_limit_q), 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0)
      $display("** course_speed_over_ground: PASSED **");
    else
      $display("** course_speed_over_ground: FAILED **");
    $finish;
  end

endmodule
